// File: rtl/core/cdmp_pkg.sv
// ----------------------------------------------------------------------------
// Closest pair search package
// Shared field widths, request kinds, the queued command and back-end states.
// ----------------------------------------------------------------------------
package cdmp_pkg;

    localparam int IDX_FIELD_W = 6;
    localparam int DIST_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int KIND_W      = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 48;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        REQ_WRITE   = 2'd0,
        REQ_FIND    = 2'd1,
        REQ_RETIRE  = 2'd2,
        REQ_RESTART = 2'd3
    } req_kind_t;

    // One classified request as it waits between the front and the back end.
    typedef struct packed {
        req_kind_t               kind;
        logic [IDX_FIELD_W-1:0]  row;
        logic [IDX_FIELD_W-1:0]  col;
        logic [DIST_W-1:0]       distance;
        logic                    in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WR_A,
        BK_WR_B,
        BK_SCAN,
        BK_FLUSH,
        BK_RESULT
    } back_state_t;

endpackage

// File: rtl/core/cdmp_front.sv
// ----------------------------------------------------------------------------
// Closest pair search front end
// Accepts request transactions, checks their indices against the store size
// and holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module cdmp_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cdmp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [cdmp_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                              q_valid,
    output cdmp_pkg::cmd_t                    q_cmd,
    input  logic                              q_pop
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CMP_W = (IDX_W + 1 > cdmp_pkg::IDX_FIELD_W) ?
                           IDX_W + 1 : cdmp_pkg::IDX_FIELD_W;

    cdmp_pkg::cmd_t    in_cmd;
    logic              row_ok;
    logic              col_ok;
    logic              push;

    cdmp_pkg::cmd_t    queue_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign row_ok = CMP_W'(s_axis_tdata[5:0]) < CMP_W'(MAX_POINTS);
    assign col_ok = CMP_W'(s_axis_tdata[11:6]) < CMP_W'(MAX_POINTS);

    always_comb
    begin
        in_cmd.kind     = cdmp_pkg::req_kind_t'(s_axis_tuser);
        in_cmd.row      = s_axis_tdata[5:0];
        in_cmd.col      = s_axis_tdata[11:6];
        in_cmd.distance = s_axis_tdata[43:12];
        unique case (in_cmd.kind)
            cdmp_pkg::REQ_WRITE:  in_cmd.in_range = row_ok && col_ok;
            cdmp_pkg::REQ_RETIRE: in_cmd.in_range = col_ok;
            default:              in_cmd.in_range = 1'b1;
        endcase
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_cmd         = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/cdmp_back.sv
// ----------------------------------------------------------------------------
// Closest pair search back end
// Owns the distance store and the active flags, carries out each queued
// command and presents its result in an output register.
// ----------------------------------------------------------------------------
module cdmp_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cdmp_pkg::COUNT_W-1:0]      point_count,
    input  logic                              q_valid,
    input  cdmp_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cdmp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PC_W   = (CNT_W > cdmp_pkg::COUNT_W) ? CNT_W : cdmp_pkg::COUNT_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    cdmp_pkg::back_state_t        state_reg;
    cdmp_pkg::back_state_t        state_next;

    cdmp_pkg::cmd_t               cmd_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [CNT_W-1:0]             i_reg;
    logic [CNT_W-1:0]             j_reg;
    logic [CNT_W-1:0]             i_next;
    logic [CNT_W-1:0]             j_next;
    logic [MAX_POINTS-1:0]        active_reg;

    logic [cdmp_pkg::DIST_W-1:0]  mem [DEPTH];
    logic [cdmp_pkg::DIST_W-1:0]  rd_data_reg;
    logic                         cand_valid_reg;
    logic [IDX_W-1:0]             cand_i_reg;
    logic [IDX_W-1:0]             cand_j_reg;

    logic [cdmp_pkg::DIST_W-1:0]  best_reg;
    logic [IDX_W-1:0]             bi_reg;
    logic [IDX_W-1:0]             bj_reg;
    logic                         have_reg;
    logic                         take_cand;

    logic                         out_valid_reg;
    logic [cdmp_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                         out_found_reg;

    logic [CNT_W-1:0]             n_in;
    logic [CNT_W-1:0]             n_m1;
    logic [CNT_W-1:0]             n_m2;
    logic                         row_end;
    logic                         scan_last;
    logic                         issue;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic                         load_out;
    logic [IDX_W-1:0]             cmd_row;
    logic [IDX_W-1:0]             cmd_col;
    logic [IDX_W-1:0]             q_col;

    // Entries beyond the store are never scanned.
    assign n_in = (PC_W'(point_count) > PC_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : CNT_W'(point_count);
    assign n_m1      = n_reg - CNT_W'(1);
    assign n_m2      = n_reg - CNT_W'(2);
    assign row_end   = (j_reg == n_m1);
    assign scan_last = row_end && (i_reg == n_m2);
    assign cmd_row   = IDX_W'(cmd_reg.row);
    assign cmd_col   = IDX_W'(cmd_reg.col);
    assign q_col     = IDX_W'(q_cmd.col);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdmp_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.kind)
                        cdmp_pkg::REQ_WRITE: state_next = cdmp_pkg::BK_WR_A;
                        cdmp_pkg::REQ_FIND:
                            state_next = (n_in < CNT_W'(2)) ? cdmp_pkg::BK_FLUSH
                                                            : cdmp_pkg::BK_SCAN;
                        default:             state_next = cdmp_pkg::BK_RESULT;
                    endcase
                end
            end
            cdmp_pkg::BK_WR_A:  state_next = cdmp_pkg::BK_WR_B;
            cdmp_pkg::BK_WR_B:  state_next = cdmp_pkg::BK_RESULT;
            cdmp_pkg::BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = cdmp_pkg::BK_FLUSH;
                end
            end
            cdmp_pkg::BK_FLUSH: state_next = cdmp_pkg::BK_RESULT;
            cdmp_pkg::BK_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = cdmp_pkg::BK_IDLE;
                end
            end
            default:            state_next = cdmp_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        issue     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = {cmd_row, cmd_col};
        load_out  = 1'b0;
        unique case (state_reg)
            cdmp_pkg::BK_IDLE:   q_pop = q_valid;
            cdmp_pkg::BK_WR_A:   mem_we = cmd_reg.in_range;
            cdmp_pkg::BK_WR_B:
            begin
                mem_we    = cmd_reg.in_range;
                mem_waddr = {cmd_col, cmd_row};
            end
            cdmp_pkg::BK_SCAN:   issue = 1'b1;
            cdmp_pkg::BK_RESULT: load_out = !out_valid_reg || m_axis_tready;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (row_end)
        begin
            i_next = i_reg + CNT_W'(1);
            j_next = i_reg + CNT_W'(2);
        end
        else
        begin
            i_next = i_reg;
            j_next = j_reg + CNT_W'(1);
        end
    end

    // Only a strictly smaller distance replaces the best, so ties keep the earlier pair.
    assign take_cand = cand_valid_reg && (!have_reg || (rd_data_reg < best_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd_reg.distance;
        end
        rd_data_reg <= mem[{i_reg[IDX_W-1:0], j_reg[IDX_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        cand_i_reg <= i_reg[IDX_W-1:0];
        cand_j_reg <= j_reg[IDX_W-1:0];
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            n_reg   <= n_in;
        end
        if (load_out)
        begin
            out_data_reg  <= {{(cdmp_pkg::OUT_DATA_W - cdmp_pkg::DIST_W
                                - 2 * cdmp_pkg::IDX_FIELD_W){1'b0}},
                              best_reg,
                              cdmp_pkg::IDX_FIELD_W'(bj_reg),
                              cdmp_pkg::IDX_FIELD_W'(bi_reg)};
            out_found_reg <= have_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdmp_pkg::BK_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            active_reg     <= '1;
            cand_valid_reg <= 1'b0;
            best_reg       <= '0;
            bi_reg         <= '0;
            bj_reg         <= '0;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cand_valid_reg <= issue && active_reg[i_reg[IDX_W-1:0]]
                                    && active_reg[j_reg[IDX_W-1:0]];
            if (q_pop)
            begin
                i_reg    <= '0;
                j_reg    <= CNT_W'(1);
                best_reg <= '0;
                bi_reg   <= '0;
                bj_reg   <= '0;
                have_reg <= 1'b0;
                if (q_cmd.kind == cdmp_pkg::REQ_RESTART)
                begin
                    active_reg <= '1;
                end
                else if (q_cmd.kind == cdmp_pkg::REQ_RETIRE && q_cmd.in_range)
                begin
                    active_reg[q_col] <= 1'b0;
                end
            end
            else
            begin
                if (issue)
                begin
                    i_reg <= i_next;
                    j_reg <= j_next;
                end
                if (take_cand)
                begin
                    best_reg <= rd_data_reg;
                    bi_reg   <= cand_i_reg;
                    bj_reg   <= cand_j_reg;
                    have_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

// File: rtl/core/cluster_distance_min_pair.sv
// ----------------------------------------------------------------------------
// Closest active pair search over a symmetric distance store
// Stores pairwise distances, retires and restores entries, and finds the
// closest pair of active entries.
// ----------------------------------------------------------------------------
//  channel   direction  signals                        contents
//  s_axis    in         tvalid tready tdata tuser      request
//  m_axis    out        tvalid tready tdata tuser      result, one per request
//  cfg       in         valid ready data               point_count
//
//  A write makes two store writes in the back end, a retire or restart only
//  updates the active flags, and a find reads all n*(n-1)/2 pairs, n being
//  point_count limited to MAX_POINTS: the single store read port gives one pair per cycle.
//  Two requests queue ahead of the back end, so input flows while a result
//  waits. Reset sets all entries active and point_count to 64; the store is
//  not cleared and holds no meaning until written.
// ----------------------------------------------------------------------------
module cluster_distance_min_pair #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] row, [11:6] col, [43:12] distance_value, [47:44] zero
    input  logic [cdmp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] req_type
    input  logic [cdmp_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] min_row, [11:6] min_col, [43:12] min_distance, [47:44] zero
    output logic [cdmp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] found
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdmp_pkg::COUNT_W-1:0]      cfg_data
);

    logic [cdmp_pkg::COUNT_W-1:0]  point_count_reg;
    logic                          q_valid;
    logic                          q_pop;
    cdmp_pkg::cmd_t                q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= cdmp_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            point_count_reg <= cfg_data;
        end
    end

    cdmp_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    cdmp_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_count   (point_count_reg),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: rtl/core/cdmp_checker.sv
// ----------------------------------------------------------------------------
// Closest pair search port checker
// Watches the result stream of the top level and flags broken results.
// ----------------------------------------------------------------------------
module cdmp_checker #(
    parameter int MAX_POINTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [cdmp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              m_axis_tuser
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // Any result without a found pair carries an all-zero payload.
    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("non-zero payload without a found pair");

    // A found pair is reported with its smaller index first.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser && (MAX_POINTS <= 64)) |->
            (m_axis_tdata[5:0] < m_axis_tdata[11:6]))
        else $error("found pair out of order");

endmodule

bind cluster_distance_min_pair cdmp_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_cdmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/tb_cluster_distance_min_pair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the closest active pair search
// Drives write, find, retire and restart requests over the request stream,
// predicts each result from a local copy of the distance store, the active
// flags and point_count, and checks every result field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_cluster_distance_min_pair;

    localparam int          STORE_POINTS  = 64;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_LIMIT   = 60000;
    localparam int          REPORT_LIMIT  = 10;
    localparam longint      RUN_LIMIT_NS  = 6_000_000;

    typedef struct packed {
        cdmp_pkg::req_kind_t                   kind;
        logic [cdmp_pkg::IDX_FIELD_W-1:0]      row;
        logic [cdmp_pkg::IDX_FIELD_W-1:0]      col;
        logic [cdmp_pkg::DIST_W-1:0]           distance;
    } pair_request_t;

    typedef struct packed {
        logic [cdmp_pkg::IDX_FIELD_W-1:0]      min_row;
        logic [cdmp_pkg::IDX_FIELD_W-1:0]      min_col;
        logic [cdmp_pkg::DIST_W-1:0]           min_distance;
        logic                                  found;
    } pair_result_t;

    logic                                clk;
    logic                                rst_n         = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [cdmp_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;
    logic [cdmp_pkg::KIND_W-1:0]         s_axis_tuser  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [cdmp_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [cdmp_pkg::COUNT_W-1:0]        cfg_data      = '0;

    // Local copy of the block's state.
    logic [cdmp_pkg::DIST_W-1:0] pair_dist    [0:STORE_POINTS-1][0:STORE_POINTS-1];
    bit                          pair_written [0:STORE_POINTS-1][0:STORE_POINTS-1];
    bit                          entry_active [0:STORE_POINTS-1];
    int unsigned                 point_count_setting;

    pair_result_t            awaited_pair_results [$];
    int unsigned             fail_count;
    int unsigned             send_idle_pct;
    int unsigned             recv_stall_pct;

    cluster_distance_min_pair #(
        .MAX_POINTS (STORE_POINTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void record_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic int unsigned scan_span();
        return (point_count_setting > STORE_POINTS) ? STORE_POINTS : point_count_setting;
    endfunction

    // Applies one request to the local state and returns the result it causes.
    function automatic pair_result_t predict_closest_pair(input pair_request_t req);
        pair_result_t res;
        int unsigned  span;
        int unsigned  i;
        int unsigned  j;
        res = '0;
        case (req.kind)
            cdmp_pkg::REQ_WRITE:
            begin
                pair_dist[req.row][req.col]    = req.distance;
                pair_dist[req.col][req.row]    = req.distance;
                pair_written[req.row][req.col] = 1'b1;
                pair_written[req.col][req.row] = 1'b1;
            end
            cdmp_pkg::REQ_FIND:
            begin
                span = scan_span();
                for (i = 0; i < span; i++)
                begin
                    if (entry_active[i])
                    begin
                        for (j = i + 1; j < span; j++)
                        begin
                            // Only a strictly smaller distance displaces the best so far.
                            if (entry_active[j]
                                && (!res.found || pair_dist[i][j] < res.min_distance))
                            begin
                                res.found        = 1'b1;
                                res.min_distance = pair_dist[i][j];
                                res.min_row      = i[cdmp_pkg::IDX_FIELD_W-1:0];
                                res.min_col      = j[cdmp_pkg::IDX_FIELD_W-1:0];
                            end
                        end
                    end
                end
            end
            cdmp_pkg::REQ_RETIRE:
                entry_active[req.col] = 1'b0;
            default:
                foreach (entry_active[k])
                    entry_active[k] = 1'b1;
        endcase
        return res;
    endfunction

    // Finds the first pair that a find would read but that has never been written.
    function automatic bit locate_unwritten_pair(output int unsigned gap_row,
                                                 output int unsigned gap_col);
        int unsigned span;
        int unsigned i;
        int unsigned j;
        span    = scan_span();
        gap_row = 0;
        gap_col = 0;
        for (i = 0; i < span; i++)
        begin
            for (j = i + 1; j < span; j++)
            begin
                if (entry_active[i] && entry_active[j] && !pair_written[i][j])
                begin
                    gap_row = i;
                    gap_col = j;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic pair_request_t make_request(
        input cdmp_pkg::req_kind_t               kind,
        input int unsigned                       row,
        input int unsigned                       col,
        input logic [cdmp_pkg::DIST_W-1:0]       distance_value);
        pair_request_t req;
        req.kind     = kind;
        req.row      = row[cdmp_pkg::IDX_FIELD_W-1:0];
        req.col      = col[cdmp_pkg::IDX_FIELD_W-1:0];
        req.distance = distance_value;
        return req;
    endfunction

    // Small values make ties common; the top value checks the full width.
    function automatic logic [cdmp_pkg::DIST_W-1:0] random_distance();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return $urandom_range(3);
        else if (pick < 35)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic send_request(input pair_request_t req);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, req.distance, req.col, req.row};
        s_axis_tuser  <= req.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        awaited_pair_results.push_back(predict_closest_pair(req));
    endtask

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (awaited_pair_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_point_count(input int unsigned value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value[cdmp_pkg::COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        point_count_setting = value & 32'h7F;
    endtask

    // Result checker, also drives the receiver's stalls.
    always @(posedge clk)
    begin : result_check
        pair_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_pair_results.size() == 0)
                begin
                    record_mismatch($sformatf("unexpected result: tdata %h found %b",
                                              m_axis_tdata, m_axis_tuser));
                end
                else
                begin
                    want = awaited_pair_results.pop_front();
                    if (m_axis_tdata[5:0] !== want.min_row
                        || m_axis_tdata[11:6] !== want.min_col
                        || m_axis_tdata[43:12] !== want.min_distance
                        || m_axis_tdata[47:44] !== 4'b0000 || m_axis_tuser !== want.found)
                    begin
                        record_mismatch($sformatf(
                            {"result mismatch: expected row %0d col %0d dist %h found %b, ",
                             "got row %0d col %0d dist %h found %b pad %h"},
                            want.min_row, want.min_col, want.min_distance, want.found,
                            m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[43:12],
                            m_axis_tuser, m_axis_tdata[47:44]));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // With fewer than two entries in use there is no pair to report.
    task automatic test_empty_counts();
        write_point_count(0);
        send_request(make_request(cdmp_pkg::REQ_FIND, $urandom_range(63), $urandom_range(63),
                                  $urandom));
        write_point_count(1);
        send_request(make_request(cdmp_pkg::REQ_FIND, $urandom_range(63), $urandom_range(63),
                                  $urandom));
    endtask

    // Four entries: ties, a diagonal write, retires down to one entry and a restart.
    task automatic test_small_matrix();
        write_point_count(4);
        send_request(make_request(cdmp_pkg::REQ_WRITE, 0, 1, 32'hFFFF_FFFF));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 2, 0, 32'h0001_0000));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 0, 3, 32'h0001_0000));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 1, 2, 32'h0001_0000));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 3, 1, 32'h8000_0000));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 2, 3, 32'hFFFF_FFFF));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 2, 2, 32'h0000_0000));
        send_request(make_request(cdmp_pkg::REQ_FIND, 0, 0, 32'h0));
        send_request(make_request(cdmp_pkg::REQ_RETIRE, $urandom_range(63), 0, $urandom));
        send_request(make_request(cdmp_pkg::REQ_FIND, 63, 63, 32'hFFFF_FFFF));
        send_request(make_request(cdmp_pkg::REQ_RETIRE, $urandom_range(63), 2, $urandom));
        send_request(make_request(cdmp_pkg::REQ_FIND, 0, 0, 32'h0));
        send_request(make_request(cdmp_pkg::REQ_RETIRE, $urandom_range(63), 1, $urandom));
        send_request(make_request(cdmp_pkg::REQ_FIND, 0, 0, 32'h0));
        send_request(make_request(cdmp_pkg::REQ_RESTART, $urandom_range(63),
                                  $urandom_range(63), $urandom));
        send_request(make_request(cdmp_pkg::REQ_FIND, 0, 0, 32'h0));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 1, 0, 32'h0000_0000));
        send_request(make_request(cdmp_pkg::REQ_FIND, 0, 0, 32'h0));
    endtask

    // A count above the store size is limited to the whole store; only a few
    // entries stay active so that every pair the scan reads has been written.
    task automatic test_saturated_count();
        int unsigned kept [4];
        int unsigned a;
        int unsigned b;
        kept = '{0, 31, 62, 63};
        write_point_count(127);
        for (a = 0; a < 4; a++)
            for (b = a + 1; b < 4; b++)
                send_request(make_request(cdmp_pkg::REQ_WRITE, kept[b], kept[a],
                                          random_distance()));
        send_request(make_request(cdmp_pkg::REQ_WRITE, 63, 63, $urandom));
        for (a = 0; a < STORE_POINTS; a++)
            if (!(a inside {kept}))
                send_request(make_request(cdmp_pkg::REQ_RETIRE, $urandom_range(63), a,
                                          $urandom));
        send_request(make_request(cdmp_pkg::REQ_FIND, $urandom_range(63), $urandom_range(63),
                                  $urandom));
        write_point_count(64);
        send_request(make_request(cdmp_pkg::REQ_FIND, $urandom_range(63), $urandom_range(63),
                                  $urandom));
        send_request(make_request(cdmp_pkg::REQ_RETIRE, $urandom_range(63), 0, $urandom));
        send_request(make_request(cdmp_pkg::REQ_FIND, $urandom_range(63), $urandom_range(63),
                                  $urandom));
        send_request(make_request(cdmp_pkg::REQ_RESTART, $urandom_range(63),
                                  $urandom_range(63), $urandom));
    endtask

    // Mostly writes and finds over a small set of entries, with retires and
    // restarts mixed in; a find whose scan would touch an unwritten pair is
    // preceded by a write of that pair.
    task automatic test_random_traffic(input int unsigned sender_pct,
                                       input int unsigned receiver_pct,
                                       input int unsigned item_total);
        int unsigned   sent;
        int unsigned   pick;
        int unsigned   span;
        int unsigned   gap_row;
        int unsigned   gap_col;
        pair_request_t req;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        write_point_count($urandom_range(12, 5));
        span = scan_span();
        for (sent = 0; sent < item_total; sent++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                if ($urandom_range(99) < 80)
                    req = make_request(cdmp_pkg::REQ_WRITE, $urandom_range(span - 1),
                                       $urandom_range(span - 1), random_distance());
                else
                    req = make_request(cdmp_pkg::REQ_WRITE, $urandom_range(63),
                                       $urandom_range(63), random_distance());
            end
            else if (pick < 75)
            begin
                if (locate_unwritten_pair(gap_row, gap_col))
                    req = make_request(cdmp_pkg::REQ_WRITE, gap_col, gap_row,
                                       random_distance());
                else
                    req = make_request(cdmp_pkg::REQ_FIND, $urandom_range(63),
                                       $urandom_range(63), $urandom);
            end
            else if (pick < 92)
            begin
                req = make_request(cdmp_pkg::REQ_RETIRE, $urandom_range(63),
                                   ($urandom_range(99) < 70) ? $urandom_range(span - 1)
                                                             : $urandom_range(63),
                                   $urandom);
            end
            else
            begin
                req = make_request(cdmp_pkg::REQ_RESTART, $urandom_range(63),
                                   $urandom_range(63), $urandom);
            end
            send_request(req);
        end
    endtask

    initial
    begin
        fail_count          = 0;
        send_idle_pct       = 32;
        recv_stall_pct      = 65;
        point_count_setting = cdmp_pkg::COUNT_RESET;
        foreach (entry_active[k])
            entry_active[k] = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_counts();
        test_small_matrix();
        test_saturated_count();
        test_random_traffic(32, 65, 65);
        test_random_traffic(65, 32, 65);
        test_random_traffic(0, 0, 65);
        drain_results();

        if (awaited_pair_results.size() != 0)
            record_mismatch($sformatf("%0d results never arrived",
                                      awaited_pair_results.size()));

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cdmp_pkg.sv
rtl/core/cdmp_front.sv
rtl/core/cdmp_back.sv
rtl/core/cluster_distance_min_pair.sv
rtl/core/cdmp_checker.sv
sim/tb_cluster_distance_min_pair.sv
